// File: hdl/u8u16_pkg.sv
// Shared types and decode functions for the UTF-8 to 16-bit code unit decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    // One input request: a byte of the string and its end marker.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_t;

    // One result request: a decoded unit and its end marker.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } out_t;

    // What the per-byte logic decides for the byte at hand.
    typedef struct packed {
        logic        emit;
        logic [1:0]  need_next;
        logic [23:0] gathered_next;
        out_t        result;
    } step_t;

    localparam logic [7:0] LEAD_TWO   = 8'h80;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_BAD   = 8'hF7;

    // Total sequence length (1 to 4) implied by a lead byte.
    function automatic logic [2:0] seq_length(input logic [7:0] lead);
        logic [2:0] len;
        if (lead < LEAD_TWO) begin
            len = 3'd1;
        end else if (lead < LEAD_THREE) begin
            len = 3'd2;
        end else if (lead < LEAD_FOUR) begin
            len = 3'd3;
        end else if (lead < LEAD_BAD) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    // Pack a sequence, lead in bits 7..0 and later bytes above it, into one unit.
    function automatic logic [15:0] pack_unit(input logic [31:0] seq);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [15:0] unit;
        b0 = seq[7:0];
        b1 = seq[15:8];
        b2 = seq[23:16];
        b3 = seq[31:24];
        if (b0 < LEAD_TWO) begin
            unit = {8'h00, b0};
        end else if (b0 < LEAD_THREE) begin
            unit = {4'h0, b0[5:2], b0[1:0], b1[5:0]};
        end else if (b0 < LEAD_FOUR) begin
            unit = {b0[3:0], b1[5:2], b1[1:0], b2[5:0]};
        end else if (b0 < LEAD_BAD) begin
            unit = {b1[3:0], b2[5:2], b2[1:0], b3[5:0]};
        end else begin
            unit = 16'h0000;
        end
        return unit;
    endfunction

endpackage

`default_nettype wire

// File: hdl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to 16-bit code unit decoder.
//
// The block takes one UTF-8 byte per input request on the s_ channel and
// returns one 16-bit code unit on the m_ channel for each completed sequence.
// Lead bytes that start multi-byte sequences are held in a small state
// register until their continuation bytes arrive; those bytes produce no
// result. A byte flagged as end of string closes any open sequence at once,
// with the missing bytes taken as zero, and its unit carries last_unit.
//
// Throughput is one byte per cycle while s_ready is high. The result of a
// byte that completes a sequence appears on m_valid in the cycle after the
// byte is accepted, from a single output register fed by the per-byte logic.
// While a result waits, a new byte is still accepted as long as the waiting
// result is taken in the same cycle or the byte produces no result; only a
// stalled result with a new result behind it holds s_ready low.
//
// Reset (aresetn low at a clock edge) drops any open sequence and empties
// the output register.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output      logic             s_ready,
    input  wire u8u16_pkg::in_t   s_data,
    output      logic             m_valid,
    input  wire logic             m_ready,
    output      u8u16_pkg::out_t  m_data
);
    import u8u16_pkg::*;

    // Sequence state: bytes still missing and the bytes gathered so far.
    logic [1:0]  need_reg;
    logic [1:0]  need_next;
    logic [23:0] gathered_reg;
    logic [23:0] gathered_next;

    // Output register.
    logic        m_valid_reg;
    logic        m_valid_next;
    out_t        m_data_reg;
    out_t        m_data_next;

    step_t       step;
    logic        s_accept;
    logic        out_free;

    u8u16_step u_step (
        .need     (need_reg),
        .gathered (gathered_reg),
        .req      (s_data),
        .step     (step)
    );

    // The output slot is free when empty or when its result leaves now.
    assign out_free = !m_valid_reg || m_ready;
    // A byte that completes no unit never needs the output slot.
    assign s_ready  = out_free || !step.emit;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        need_next     = need_reg;
        gathered_next = gathered_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            need_next     = step.need_next;
            gathered_next = step.gathered_next;
            if (step.emit) begin
                m_valid_next = 1'b1;
                m_data_next  = step.result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            need_reg    <= need_next;
            m_valid_reg <= m_valid_next;
        end
        gathered_reg <= gathered_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // An end-of-string byte always closes the open sequence.
    a_eos_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.end_of_string) |=> (need_reg == 2'd0))
        else $error("end of string left a sequence open");

    // An open sequence always has a lead byte that calls for more bytes.
    a_open_lead: assert property (@(posedge aclk) disable iff (!aresetn)
        (need_reg != 2'd0) |-> ((gathered_reg[7:0] >= LEAD_TWO)
                                && (gathered_reg[7:0] < LEAD_BAD)))
        else $error("open sequence with a single-byte lead");

    // The missing-byte count only counts down or closes.
    a_need_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (need_reg != 2'd0)) |=>
            ((need_reg == 2'd0) || (need_reg == $past(need_reg) - 2'd1)))
        else $error("missing-byte count did not count down");

    // A result that is not taken is never overwritten by a new one.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(s_accept && step.emit))
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

// File: hdl/u8u16_step.sv
// Per-byte decode logic: next sequence state and the unit a byte completes.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_step (
    input  wire logic [1:0]       need,
    input  wire logic [23:0]      gathered,
    input  wire u8u16_pkg::in_t   req,
    output u8u16_pkg::step_t      step
);
    import u8u16_pkg::*;

    logic [2:0]  lead_len;
    logic [2:0]  open_len;
    logic [2:0]  len_left;
    logic [1:0]  slot;
    logic [31:0] seq;
    logic [1:0]  need_dec;

    always_comb begin
        lead_len = seq_length(req.in_byte);
        open_len = seq_length(gathered[7:0]);
        len_left = open_len - {1'b0, need};
        need_dec = need - 2'd1;

        // Byte slot of the incoming byte within the open sequence.
        if (open_len > {1'b0, need}) begin
            slot = (len_left > 3'd3) ? 2'd3 : len_left[1:0];
        end else begin
            slot = 2'd1;
        end

        case (slot)
            2'd2:    seq = {8'h00, req.in_byte, gathered[15:0]};
            2'd3:    seq = {req.in_byte, gathered};
            default: seq = {8'h00, gathered[23:16], req.in_byte, gathered[7:0]};
        endcase

        step.result.last_unit = req.end_of_string;
        if (need == 2'd0) begin
            step.result.code_unit = pack_unit({24'h000000, req.in_byte});
            if ((lead_len == 3'd1) || req.end_of_string) begin
                step.emit          = 1'b1;
                step.need_next     = 2'd0;
                step.gathered_next = 24'h000000;
            end else begin
                step.emit          = 1'b0;
                step.need_next     = 2'(lead_len - 3'd1);
                step.gathered_next = {16'h0000, req.in_byte};
            end
        end else begin
            step.result.code_unit = pack_unit(seq);
            if ((need_dec == 2'd0) || req.end_of_string) begin
                step.emit          = 1'b1;
                step.need_next     = 2'd0;
                step.gathered_next = 24'h000000;
            end else begin
                step.emit          = 1'b0;
                step.need_next     = need_dec;
                step.gathered_next = seq[23:0];
            end
        end
    end

endmodule

`default_nettype wire
